>>> src/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared constants, command codes and controller/datapath interface types
// for the sorted list block.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

  // Default capacity of the list.
  localparam int unsigned SLI_DEPTH = 16;

  // Field widths of one input item and one result item.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // Stream data widths, padded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operation codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_MAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;

  // Index register operations.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_USED,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Memory read address relative to the index register.
  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_sel_t;

  // Memory write data source.
  typedef enum logic {
    WR_VALUE,
    WR_RDATA
  } wr_sel_t;

  // Fill count operations.
  typedef enum logic [1:0] {
    USED_HOLD,
    USED_INC,
    USED_DEC
  } used_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    idx_op_t  idx_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    used_op_t used_op;
    logic     res_set;
    logic     res_ok;
    logic     res_take_rd;
    logic     out_load;
  } sli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_eq_used;
    logic idx_last;
    logic rd_gt_val;
    logic rd_eq_val;
  } sli_stat_t;

endpackage : sli_pkg

`default_nettype wire

>>> src/sli_dpath.sv
// ----------------------------------------------------------------------------
// Sorted list datapath
// Entry memory, index and fill count registers, comparators and the
// result and output payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_dpath
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = SLI_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire sli_cmd_t                  cmd,
  output sli_stat_t                      stat,
  output logic                           out_ok,
  output logic signed [VALUE_W-1:0]      out_removed_value,
  output logic [COUNT_W-1:0]             out_count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry memory, one write and one registered read port.
  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  logic signed [VALUE_W-1:0] value_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             idx_nxt;
  logic [CW-1:0]             used_r;
  logic [CW-1:0]             used_nxt;
  logic                      res_ok_r;
  logic signed [VALUE_W-1:0] res_removed_r;
  logic [CW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic [CW:0]               idx_p1;
  logic [CW+COUNT_W-1:0]     used_ext;

  assign idx_p1   = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};
  assign used_ext = {{COUNT_W{1'b0}}, used_r};

  // Read address and write data selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_addr = idx_r - {{(CW-1){1'b0}}, 1'b1};
      RD_CUR:  rd_addr = idx_r;
      RD_NEXT: rd_addr = idx_p1[CW-1:0];
      default: rd_addr = idx_r;
    endcase
    unique case (cmd.wr_sel)
      WR_VALUE: wr_data = value_r;
      WR_RDATA: wr_data = rd_data_r;
      default:  wr_data = value_r;
    endcase
  end

  // Memory access.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx_r[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  // Next index and fill count.
  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_ZERO: idx_nxt = '0;
      IDX_USED: idx_nxt = used_r;
      IDX_INC:  idx_nxt = idx_p1[CW-1:0];
      IDX_DEC:  idx_nxt = idx_r - {{(CW-1){1'b0}}, 1'b1};
      default:  idx_nxt = idx_r;
    endcase
    unique case (cmd.used_op)
      USED_HOLD: used_nxt = used_r;
      USED_INC:  used_nxt = used_r + {{(CW-1){1'b0}}, 1'b1};
      USED_DEC:  used_nxt = used_r - {{(CW-1){1'b0}}, 1'b1};
      default:   used_nxt = used_r;
    endcase
  end

  // The fill count is the only control state here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_in) begin
      value_r <= in_value;
    end
    if (cmd.res_set) begin
      res_ok_r      <= cmd.res_ok;
      res_removed_r <= cmd.res_take_rd ? rd_data_r : '0;
    end
    if (cmd.out_load) begin
      out_ok            <= res_ok_r;
      out_removed_value <= res_removed_r;
      out_count         <= used_ext[COUNT_W-1:0];
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.full        = (used_r == CW'(DEPTH));
    stat.empty       = (used_r == '0);
    stat.idx_zero    = (idx_r == '0);
    stat.idx_eq_used = (idx_r == used_r);
    stat.idx_last    = (idx_p1 == {1'b0, used_r});
    stat.rd_gt_val   = (rd_data_r > value_r);
    stat.rd_eq_val   = (rd_data_r == value_r);
  end

endmodule : sli_dpath

`default_nettype wire

>>> src/sli_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list controller
// Sequences insert, remove-largest and remove-value operations over the
// datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ctrl
  import sli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire sli_stat_t        stat,
  output sli_cmd_t              cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_POP_RD,
    ST_POP_CMP,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_sel    = RD_CUR;
    cmd.wr_sel    = WR_VALUE;
    cmd.used_op   = USED_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          priority if (in_cmd == CMD_INSERT) begin
            if (stat.full) begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.idx_op = IDX_USED;
              state_nxt  = ST_INS_RD;
            end
          end else if (in_cmd == CMD_POP_MAX) begin
            if (stat.empty) begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.idx_op = IDX_USED;
              state_nxt  = ST_POP_RD;
            end
          end else if (in_cmd == CMD_DELETE) begin
            cmd.idx_op = IDX_ZERO;
            state_nxt  = ST_DEL_RD;
          end else begin
            // Unused code: report failure, list untouched.
            cmd.res_set = 1'b1;
            state_nxt   = ST_FINISH;
          end
        end
      end
      // Insert walks down from the top, moving larger entries up by one.
      ST_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.used_op = USED_INC;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_gt_val) begin
          cmd.wr_sel = WR_RDATA;
          cmd.idx_op = IDX_DEC;
          state_nxt  = ST_INS_RD;
        end else begin
          cmd.used_op = USED_INC;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = ST_FINISH;
        end
      end
      // Remove-largest reads the last entry.
      ST_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        state_nxt  = ST_POP_CMP;
      end
      ST_POP_CMP: begin
        cmd.used_op     = USED_DEC;
        cmd.res_set     = 1'b1;
        cmd.res_ok      = 1'b1;
        cmd.res_take_rd = 1'b1;
        state_nxt       = ST_FINISH;
      end
      // Remove-value scans up from the bottom for the first match.
      ST_DEL_RD: begin
        if (stat.idx_eq_used) begin
          cmd.res_set = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_nxt  = ST_DEL_CMP;
        end
      end
      ST_DEL_CMP: begin
        if (stat.rd_eq_val) begin
          state_nxt = ST_SH_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = ST_DEL_RD;
        end
      end
      // Close the gap by moving later entries down by one.
      ST_SH_RD: begin
        if (stat.idx_last) begin
          cmd.used_op = USED_DEC;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_nxt  = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RDATA;
        cmd.idx_op = IDX_INC;
        state_nxt  = ST_SH_RD;
      end
      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : sli_ctrl

`default_nettype wire

>>> src/sorted_list_insert_delete_top.sv
// Insert moves each larger entry up by one from the top, then writes the value; remove-largest
// reads the last entry; remove-value scans up from the bottom for the first match, then moves
// each later entry down by one. A rejected insert, a pop of an empty list and the unused code
// go straight to the result. The sequencer works one item at a time over the single entry
// memory port pair. A result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) empties the list; no clearing pass.
// ----------------------------------------------------------------------------
// Sorted list top level
// Fixed-capacity ascending list of signed values with insert, remove-largest
// and remove-value operations on stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete_top
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = SLI_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] cmd, [33:2] value, [39:34] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] ok, [32:1] removed_value, [37:33] count, [39:38] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  sli_cmd_t                  cmd;
  sli_stat_t                 stat;
  logic [CMD_W-1:0]          in_cmd;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_ok;
  logic signed [VALUE_W-1:0] out_removed_value;
  logic [COUNT_W-1:0]        out_count;

  // Unpack input fields.
  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_value = in_tdata[CMD_W+VALUE_W-1:CMD_W];

  // Pack result fields.
  assign out_tdata = {{(OUT_TDATA_W-1-VALUE_W-COUNT_W){1'b0}},
                      out_count, out_removed_value, out_ok};

  sli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sli_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_value          (in_value),
    .cmd               (cmd),
    .stat              (stat),
    .out_ok            (out_ok),
    .out_removed_value (out_removed_value),
    .out_count         (out_count)
  );

endmodule : sorted_list_insert_delete_top

`default_nettype wire

>>> src/sli_checker.sv
// ----------------------------------------------------------------------------
// Sorted list port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_checker
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = SLI_DEPTH
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One item at a time: no accept in the cycle right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A failed operation reports zero as removed value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0)
    else $error("nonzero removed value on failure");

  // The reported count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 31) || (32'(out_tdata[37:33]) <= DEPTH))
    else $error("count above capacity");

endmodule : sli_checker

bind sorted_list_insert_delete_top sli_checker #(
  .DEPTH (DEPTH)
) u_sli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
